### hw/rtl/modular_number_theory_alu_macros.svh
// Assertion helpers for the file that checks itself.
`ifndef MODULAR_NUMBER_THEORY_ALU_MACROS_SVH
`define MODULAR_NUMBER_THEORY_ALU_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define MNTA_ASSERT_NOW(label, clk_sig, rst_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> (cons)) \
        else $error("modular_number_theory_alu: check failed");

// Next-cycle implication, disabled while reset is asserted
`define MNTA_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |=> (cons)) \
        else $error("modular_number_theory_alu: check failed");

`endif

### hw/rtl/mnt_alu_pkg.sv
`timescale 1ns / 1ps

package mnt_alu_pkg;

    // Port field widths
    localparam int DATA_BITS     = 32;
    localparam int CMD_BITS      = 2;
    localparam int WORD_BITS_DEF = 32;

    // Command codes
    localparam logic [CMD_BITS-1:0] CMD_MODMUL = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_MODEXP = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_LCM    = 2'd2;

    typedef struct packed {
        logic [CMD_BITS-1:0]  command;
        logic [DATA_BITS-1:0] operand_a;
        logic [DATA_BITS-1:0] operand_b;
        logic [DATA_BITS-1:0] modulus;
    } req_item_t;

    typedef struct packed {
        logic [DATA_BITS-1:0] result;
        logic                 overflow;
    } rsp_item_t;

    // Divider status towards the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

### hw/rtl/mnt_alu_mul.sv
`timescale 1ns / 1ps

// Word multiplier with registered double-width product
module mnt_alu_mul #(
    parameter int W = mnt_alu_pkg::WORD_BITS_DEF
) (
    input  logic           clk,
    input  logic [W-1:0]   x,
    input  logic [W-1:0]   y,
    output logic [2*W-1:0] product
);

    logic [2*W-1:0] product_reg;
    logic [2*W-1:0] product_next;

    assign product_next = {{W{1'b0}}, x} * {{W{1'b0}}, y};

    always_ff @(posedge clk)
    begin
        product_reg <= product_next;
    end

    assign product = product_reg;

endmodule

### hw/rtl/mnt_alu_div.sv
`timescale 1ns / 1ps

// Restoring divider: double-width dividend by a word, one quotient bit per cycle.
// Divisor must be nonzero at start.
module mnt_alu_div #(
    parameter int W = mnt_alu_pkg::WORD_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [2*W-1:0]            dividend,
    input  logic [W-1:0]              divisor,
    output logic [2*W-1:0]            quotient,
    output logic [W-1:0]              remainder,
    output mnt_alu_pkg::div_status_t  status
);

    localparam int DW       = 2 * W;
    localparam int CNT_BITS = $clog2(DW + 1);

    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                done_reg, done_next;
    logic [W-1:0]        rem_reg, rem_next;
    logic [DW-1:0]       dq_reg, dq_next;
    logic [W-1:0]        dvs_reg, dvs_next;

    logic [W:0]          trial;
    logic [W:0]          diff;
    logic                ge;

    // One trial subtraction per cycle
    always_comb
    begin
        trial = {rem_reg, dq_reg[DW-1]};
        diff  = trial - {1'b0, dvs_reg};
        ge    = (trial >= {1'b0, dvs_reg});

        cnt_next  = cnt_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        dq_next   = dq_reg;
        dvs_next  = dvs_reg;

        if (start)
        begin
            cnt_next = CNT_BITS'(DW);
            rem_next = '0;
            dq_next  = dividend;
            dvs_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - CNT_BITS'(1);
            rem_next  = ge ? diff[W-1:0] : trial[W-1:0];
            dq_next   = {dq_reg[DW-2:0], ge};
            done_next = (cnt_reg == CNT_BITS'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dq_reg  <= dq_next;
        dvs_reg <= dvs_next;
    end

    assign quotient    = dq_reg;
    assign remainder   = rem_reg;
    assign status.busy = (cnt_reg != '0);
    assign status.done = done_reg;

endmodule

### hw/rtl/modular_number_theory_alu.sv
`timescale 1ns / 1ps
// Modular number-theory unit: modular multiply, modular exponentiation and lcm.
// Request channel req_valid / req_ready / req carries command and operands; the
// response channel rsp_valid / rsp_ready / rsp returns one result item per request.
// Operands are taken in their low WORD_BITS bits; results are zero-extended.
// One item is in work at a time: req_ready is high only while the sequencer idles.
// All work runs through one registered word multiplier and one bit-serial
// divider; a modular multiply is one product followed by its reduction; an
// exponentiation reduces its base, then does one squaring per exponent bit
// above the lowest and one multiply per set bit; lcm runs one division per
// Euclid step, divides a by the gcd and multiplies that, unreduced, by b.
// Zero modulus, zero exponent, zero lcm operands and the spare code go
// straight to the result.
// With the receiver ready, the next request is taken at the edge after rsp_valid rises.
// A finished result waits in an output register; if rsp_ready is low the
// sequencer still takes the next request, but holds its answer until the register frees.
// Reset clears the sequencer and drops rsp_valid; no state is kept between items.
`include "modular_number_theory_alu_macros.svh"

module modular_number_theory_alu #(
    parameter int WORD_BITS = mnt_alu_pkg::WORD_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    req_valid,
    output logic                    req_ready,
    input  mnt_alu_pkg::req_item_t  req,
    output logic                    rsp_valid,
    input  logic                    rsp_ready,
    output mnt_alu_pkg::rsp_item_t  rsp
);

    localparam int W  = WORD_BITS;
    localparam int DW = 2 * W;

    // Sequencer states
    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_MUL      = 3'd1;
    localparam logic [2:0] ST_PROD     = 3'd2;
    localparam logic [2:0] ST_DIV_GO   = 3'd3;
    localparam logic [2:0] ST_DIV_WAIT = 3'd4;
    localparam logic [2:0] ST_DONE     = 3'd5;

    // What the current multiply / divide is for
    localparam logic [2:0] STEP_MODMUL = 3'd0;
    localparam logic [2:0] STEP_BASE   = 3'd1;
    localparam logic [2:0] STEP_ACC    = 3'd2;
    localparam logic [2:0] STEP_SQR    = 3'd3;
    localparam logic [2:0] STEP_GCD    = 3'd4;
    localparam logic [2:0] STEP_QUOT   = 3'd5;
    localparam logic [2:0] STEP_LCM    = 3'd6;

    logic [2:0]   state_reg, state_next;
    logic [2:0]   step_reg, step_next;
    logic         out_valid_reg, out_valid_next;
    mnt_alu_pkg::rsp_item_t out_item_reg, out_item_next;

    // a: operand a; b: operand b / remaining exponent; m: modulus
    // u, v: accumulator and square for exponentiation, x and y for Euclid
    logic [W-1:0] a_reg, a_next;
    logic [W-1:0] b_reg, b_next;
    logic [W-1:0] m_reg, m_next;
    logic [W-1:0] u_reg, u_next;
    logic [W-1:0] v_reg, v_next;
    logic [W-1:0] res_reg, res_next;
    logic         ovf_reg, ovf_next;

    logic [W-1:0]  mul_x, mul_y;
    logic [DW-1:0] product;

    logic          div_start;
    logic [DW-1:0] div_dividend;
    logic [W-1:0]  div_divisor;
    logic [DW-1:0] div_quot;
    logic [W-1:0]  div_rem;
    mnt_alu_pkg::div_status_t div_stat;

    logic [W-1:0] req_a, req_b, req_m;

    assign req_a = req.operand_a[W-1:0];
    assign req_b = req.operand_b[W-1:0];
    assign req_m = req.modulus[W-1:0];

    // Shared arithmetic units
    mnt_alu_mul #(.W(W)) u_mul (
        .clk     (clk),
        .x       (mul_x),
        .y       (mul_y),
        .product (product)
    );

    mnt_alu_div #(.W(W)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .quotient  (div_quot),
        .remainder (div_rem),
        .status    (div_stat)
    );

    // Multiplier operand selection
    always_comb
    begin
        unique case (step_reg)
            STEP_ACC:
            begin
                mul_x = u_reg;
                mul_y = v_reg;
            end
            STEP_SQR:
            begin
                mul_x = v_reg;
                mul_y = v_reg;
            end
            STEP_LCM:
            begin
                mul_x = u_reg;
                mul_y = b_reg;
            end
            default:
            begin
                mul_x = a_reg;
                mul_y = b_reg;
            end
        endcase
    end

    // Divider operand selection
    always_comb
    begin
        unique case (step_reg)
            STEP_BASE:
            begin
                div_dividend = DW'(a_reg);
                div_divisor  = m_reg;
            end
            STEP_GCD:
            begin
                div_dividend = DW'(u_reg);
                div_divisor  = v_reg;
            end
            STEP_QUOT:
            begin
                div_dividend = DW'(a_reg);
                div_divisor  = u_reg;
            end
            default:
            begin
                div_dividend = product;
                div_divisor  = m_reg;
            end
        endcase
    end

    assign div_start = (state_reg == ST_DIV_GO) ||
                       ((state_reg == ST_PROD) && (step_reg != STEP_LCM));

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        m_next         = m_reg;
        u_next         = u_reg;
        v_next         = v_reg;
        res_next       = res_reg;
        ovf_next       = ovf_reg;

        if (out_valid_reg && rsp_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    a_next   = req_a;
                    b_next   = req_b;
                    m_next   = req_m;
                    res_next = '0;
                    ovf_next = 1'b0;
                    unique case (req.command)
                        mnt_alu_pkg::CMD_MODMUL:
                        begin
                            if (req_m == '0)
                            begin
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                step_next  = STEP_MODMUL;
                                state_next = ST_MUL;
                            end
                        end
                        mnt_alu_pkg::CMD_MODEXP:
                        begin
                            if (req_m == '0)
                            begin
                                state_next = ST_DONE;
                            end
                            else if (req_b == '0)
                            begin
                                // exponent zero: plain 1, not reduced
                                res_next   = W'(1);
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                u_next     = W'(1);
                                step_next  = STEP_BASE;
                                state_next = ST_DIV_GO;
                            end
                        end
                        mnt_alu_pkg::CMD_LCM:
                        begin
                            if ((req_a == '0) || (req_b == '0))
                            begin
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                u_next     = req_a;
                                v_next     = req_b;
                                step_next  = STEP_GCD;
                                state_next = ST_DIV_GO;
                            end
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_MUL:
            begin
                // product registers this cycle
                state_next = ST_PROD;
            end

            ST_PROD:
            begin
                if (step_reg == STEP_LCM)
                begin
                    res_next   = product[W-1:0];
                    ovf_next   = |product[DW-1:W];
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_DIV_WAIT;
                end
            end

            ST_DIV_GO:
            begin
                state_next = ST_DIV_WAIT;
            end

            ST_DIV_WAIT:
            begin
                if (div_stat.done)
                begin
                    unique case (step_reg)
                        STEP_MODMUL:
                        begin
                            res_next   = div_rem;
                            state_next = ST_DONE;
                        end
                        STEP_BASE:
                        begin
                            v_next     = div_rem;
                            step_next  = b_reg[0] ? STEP_ACC : STEP_SQR;
                            state_next = ST_MUL;
                        end
                        STEP_ACC:
                        begin
                            u_next = div_rem;
                            if (b_reg[W-1:1] == '0)
                            begin
                                // last exponent bit: skip the final squaring
                                res_next   = div_rem;
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                step_next  = STEP_SQR;
                                state_next = ST_MUL;
                            end
                        end
                        STEP_SQR:
                        begin
                            v_next     = div_rem;
                            b_next     = b_reg >> 1;
                            step_next  = b_reg[1] ? STEP_ACC : STEP_SQR;
                            state_next = ST_MUL;
                        end
                        STEP_GCD:
                        begin
                            u_next = v_reg;
                            v_next = div_rem;
                            if (div_rem == '0)
                            begin
                                step_next = STEP_QUOT;
                            end
                            state_next = ST_DIV_GO;
                        end
                        STEP_QUOT:
                        begin
                            u_next     = div_quot[W-1:0];
                            step_next  = STEP_LCM;
                            state_next = ST_MUL;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    out_valid_next         = 1'b1;
                    out_item_next.result   = mnt_alu_pkg::DATA_BITS'(res_reg);
                    out_item_next.overflow = ovf_reg;
                    state_next             = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= STEP_MODMUL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working values
    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        m_reg        <= m_next;
        u_reg        <= u_next;
        v_reg        <= v_next;
        res_reg      <= res_next;
        ovf_reg      <= ovf_next;
    end

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_item_reg;

    // Checks
    `MNTA_ASSERT_NOW(a_div_start_idle, clk, rst_n, div_start, !div_stat.busy)
    `MNTA_ASSERT_NOW(a_div_nonzero, clk, rst_n, div_start, div_divisor != '0)
    `MNTA_ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, req_valid && req_ready, state_reg != ST_IDLE)
    `MNTA_ASSERT_NOW(a_rsp_from_done, clk, rst_n, $rose(rsp_valid), $past(state_reg) == ST_DONE)

endmodule
